@@ sv/tccu_pkg.sv @@
// ----------------------------------------------------------------------------
// tccu_pkg
// Shared types, codes and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tccu_pkg;

  // field widths
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  // width of row * columns + column before masking
  localparam int MUL_W      = ROW_W + COL_W + 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MOVE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP = 2'd2;

  // configuration reset values
  localparam logic [COLOR_W-1:0] FG_RESET  = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET  = 4'd0;
  localparam logic [ROW_W-1:0]   TOP_RESET = 5'd1;

  // control characters
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // blank light gray on black
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // one accepted input item, coordinates already saturated
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  tcol;
    logic [ROW_W-1:0]  trow;
  } item_t;

  // attribute byte above the character byte
  function automatic logic [CELL_W-1:0] make_cell(logic [COLOR_W-1:0] fg,
                                                  logic [COLOR_W-1:0] bg,
                                                  logic [CHAR_W-1:0]  ch);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

@@ sv/tccu_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tccu_screen_ram
// Screen store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tccu_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tccu_pkg::CELL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tccu_pkg::CELL_W-1:0] rdata_o
);
  import tccu_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tccu_tab_unit.sv @@
// ----------------------------------------------------------------------------
// tccu_tab_unit
// Next tab stop after a column: the next multiple of the tab width.
// ----------------------------------------------------------------------------
module tccu_tab_unit #(
  parameter int TAB_WIDTH = 8
) (
  input  logic [tccu_pkg::COL_W-1:0] col_i,
  output logic [tccu_pkg::COL_W:0]   next_o
);
  import tccu_pkg::*;

  localparam int NSTOP = (1 << COL_W) / TAB_WIDTH;

  logic [NSTOP-1:0] passed;

  // one compare per tab stop, set when the stop is at or left of the column
  for (genvar k = 0; k < NSTOP; k++) begin : g_stop
    localparam int STOP = (k + 1) * TAB_WIDTH;
    assign passed[k] = ({1'b0, col_i} >= (COL_W + 1)'(STOP));
  end

  // stops passed plus one, times the tab width
  assign next_o = (COL_W + 1)'(($countones(passed) + 1) * TAB_WIDTH);

endmodule

@@ sv/text_console_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Character-cell text console: screen store, cursor and scroll sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one action per transfer:
//   put char, backspace, clear area, move cursor or read cell. Each transfer
//   yields exactly one result transfer (out_valid_o / out_ready_i) with the
//   cursor column, row and linear position, plus the cell for read cell.
//   Configuration (colors, top terminal row) is written through cfg_we_i,
//   cfg_index_i and cfg_data_i and taken at once. The user must write it
//   only while the block is idle; the block itself does not enforce this.
// Sequencing:
//   Each action is worked in S_EXEC and its result loaded in S_DONE; read
//   cell waits in S_RDWAIT between them. A line feed past the last row adds
//   a scroll that moves the rows below the top terminal row one row up and
//   blanks the bottom row; clear area blanks the top terminal row onward.
//   The single-port store write paces both, one cell per cycle.
// Reset:
//   After reset a clearing pass writes blanks to all ROWS*COLUMNS cells,
//   one per cycle, during which in_ready_o is low.
// Stall:
//   A result waits in the output register; the next item is accepted and
//   worked, and it waits in its final step until the output register frees.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [tccu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tccu_pkg::ACT_W-1:0]      action_i,
  input  logic [tccu_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tccu_pkg::COL_W-1:0]      target_column_i,
  input  logic [tccu_pkg::ROW_W-1:0]      target_row_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tccu_pkg::COL_W-1:0]      cursor_column_o,
  output logic [tccu_pkg::ROW_W-1:0]      cursor_row_o,
  output logic [tccu_pkg::POS_W-1:0]      cursor_position_o,
  output logic [tccu_pkg::CELL_W-1:0]     cell_word_o
);
  import tccu_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int IW         = $clog2(CELL_COUNT);
  localparam int PW         = $clog2(CELL_COUNT + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_RDWAIT, S_COPY, S_FILL, S_DONE
  } state_e;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PW-1:0]      ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [IW-1:0]      wa_q, wa_d;
  logic [CELL_W-1:0]  word_q, word_d;
  logic [COLOR_W-1:0] fg_q, fg_d;
  logic [COLOR_W-1:0] bg_q, bg_d;
  logic [ROW_W-1:0]   top_q, top_d;
  logic               out_valid_q, out_valid_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic [ROW_W-1:0]   out_row_q, out_row_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [CELL_W-1:0]  out_word_q, out_word_d;

  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;

  logic [ROW_W-1:0]   eff_top, row_up;
  logic [CELL_W-1:0]  blank;
  logic [COL_W:0]     tab_next;
  logic               do_nl;
  logic               copy_rd;
  logic [COL_W-1:0]   tcol_sat;
  logic [ROW_W-1:0]   trow_sat;
  logic [COL_W-1:0]   bs_col;
  logic [ROW_W-1:0]   bs_row;

  // linear cell index before masking
  function automatic logic [MUL_W-1:0] lin(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    lin = MUL_W'(r) * MUL_W'(COLUMNS) + MUL_W'(c);
  endfunction

  tccu_screen_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tccu_tab_unit #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_tab (
    .col_i  (col_q),
    .next_o (tab_next)
  );

  // effective top row, cursor raised into the terminal area, blank cell
  assign eff_top = ({1'b0, top_q} >= (ROW_W + 1)'(ROWS)) ? ROW_W'(ROWS - 1) : top_q;
  assign row_up  = (row_q < eff_top) ? eff_top : row_q;
  assign blank   = make_cell(fg_q, bg_q, CH_SPACE);

  // input coordinates saturate to the screen
  assign tcol_sat = ({1'b0, target_column_i} >= (COL_W + 1)'(COLUMNS)) ?
                    COL_W'(COLUMNS - 1) : target_column_i;
  assign trow_sat = ({1'b0, target_row_i} >= (ROW_W + 1)'(ROWS)) ?
                    ROW_W'(ROWS - 1) : target_row_i;

  // backspace target
  always_comb begin
    bs_col = col_q;
    bs_row = row_q;
    if (col_q != '0) begin
      bs_col = col_q - COL_W'(1);
    end else if (row_q > eff_top) begin
      bs_row = row_q - ROW_W'(1);
      bs_col = COL_W'(COLUMNS - 1);
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    col_d       = col_q;
    row_d       = row_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    wa_d        = wa_q;
    word_d      = word_q;
    fg_d        = fg_q;
    bg_d        = bg_q;
    top_d       = top_q;
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_pos_d   = out_pos_q;
    out_word_d  = out_word_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = blank;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    do_nl       = 1'b0;
    copy_rd     = 1'b0;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FG:  fg_d  = cfg_data_i[COLOR_W-1:0];
        CFG_BG:  bg_d  = cfg_data_i[COLOR_W-1:0];
        CFG_TOP: top_d = cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end

    // result transfer frees the output register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // clearing pass after reset
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[IW-1:0];
        mem_wdata = RESET_CELL;
        ptr_d     = ptr_q + PW'(1);
        if (ptr_q == PW'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d.action    = action_i;
          item_d.char_code = char_code_i;
          item_d.tcol      = tcol_sat;
          item_d.trow      = trow_sat;
          word_d           = '0;
          state_d          = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (item_q.action)
          ACT_PUT: begin
            row_d = row_up;
            if (item_q.char_code == CH_LF) begin
              do_nl = 1'b1;
            end else if (item_q.char_code == CH_CR) begin
              col_d = '0;
            end else if (item_q.char_code == CH_TAB) begin
              if (tab_next >= (COL_W + 1)'(COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_d = tab_next[COL_W-1:0];
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = IW'(lin(row_up, col_q));
              mem_wdata = make_cell(fg_q, bg_q, item_q.char_code);
              if ({1'b0, col_q} + (COL_W + 1)'(1) >= (COL_W + 1)'(COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
            // new line, scrolling past the last row
            if (do_nl) begin
              col_d = '0;
              if ({1'b0, row_up} + (ROW_W + 1)'(1) >= (ROW_W + 1)'(ROWS)) begin
                row_d   = ROW_W'(ROWS - 1);
                ptr_d   = PW'(lin(eff_top, '0) + MUL_W'(COLUMNS));
                pend_d  = 1'b0;
                state_d = S_COPY;
              end else begin
                row_d = row_up + ROW_W'(1);
              end
            end
          end
          ACT_BACK: begin
            col_d     = bs_col;
            row_d     = bs_row;
            mem_we    = 1'b1;
            mem_waddr = IW'(lin(bs_row, bs_col));
            mem_wdata = blank;
          end
          ACT_CLEAR: begin
            col_d   = '0;
            row_d   = eff_top;
            ptr_d   = PW'(lin(eff_top, '0));
            state_d = S_FILL;
          end
          ACT_MOVE: begin
            col_d = item_q.tcol;
            row_d = item_q.trow;
          end
          ACT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = IW'(lin(item_q.trow, item_q.tcol));
            state_d   = S_RDWAIT;
          end
          default: ;
        endcase
      end

      S_RDWAIT: begin
        word_d  = mem_rdata;
        state_d = S_DONE;
      end

      // scroll: read a cell, write it one row up in the next cycle
      S_COPY: begin
        copy_rd = (ptr_q != PW'(CELL_COUNT));
        if (copy_rd) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[IW-1:0];
          ptr_d     = ptr_q + PW'(1);
        end
        pend_d = copy_rd;
        wa_d   = IW'(ptr_q - PW'(COLUMNS));
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = mem_rdata;
        end
        if (!copy_rd && !pend_q) begin
          ptr_d   = PW'((ROWS - 1) * COLUMNS);
          state_d = S_FILL;
        end
      end

      // blank from the pointer to the end of the store
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[IW-1:0];
        mem_wdata = blank;
        ptr_d     = ptr_q + PW'(1);
        if (ptr_q == PW'(CELL_COUNT - 1)) begin
          state_d = S_DONE;
        end
      end

      // load the result once the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_col_d   = col_q;
          out_row_d   = row_q;
          out_pos_d   = POS_W'(lin(row_q, col_q));
          out_word_d  = word_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      item_q      <= '0;
      col_q       <= '0;
      row_q       <= TOP_RESET;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      wa_q        <= '0;
      word_q      <= '0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      top_q       <= TOP_RESET;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_pos_q   <= '0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      wa_q        <= wa_d;
      word_q      <= word_d;
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_pos_q   <= out_pos_d;
      out_word_q  <= out_word_d;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_column_o   = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_position_o = out_pos_q;
  assign cell_word_o       = out_word_q;

`ifndef ASSERT_OFF
  // cursor stays on the screen
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < (COL_W + 1)'(COLUMNS)) && ({1'b0, row_q} < (ROW_W + 1)'(ROWS)))
    else $error("cursor left the screen");

  // an accepted item blocks the input until it is done
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // a scroll copy write follows a read of the store in the cycle before
  a_copy_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && pend_q) |-> (state_q == S_COPY) && $past(mem_re))
    else $error("copy write without a preceding read");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_pos_q) && out_valid_q)
    else $error("waiting result overwritten");
`endif

endmodule

@@ test/text_console_cursor_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit_tb
// Self-checking bench for the text console: directed and random console
// commands under random input gaps and result stalls, checked transfer by
// transfer against a shadow of the screen store, cursor and color settings.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit_tb;
  import tccu_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int MAX_WAIT        = 19;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int QUIET_LIMIT     = 20000;
  localparam int REPORT_CAP      = 200;

  // codes the package leaves unnamed
  localparam logic [ACT_W-1:0]     ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0]     ACT_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE        = 2'd3;

  // one queued command: either a register write or a console item
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [ACT_W-1:0]      action;
    logic [CHAR_W-1:0]     ch;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_val;
  } cursor_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ACT_W-1:0]      action_i = '0;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [COL_W-1:0]      target_column_i = '0;
  logic [ROW_W-1:0]      target_row_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COL_W-1:0]      cursor_column_o;
  logic [ROW_W-1:0]      cursor_row_o;
  logic [POS_W-1:0]      cursor_position_o;
  logic [CELL_W-1:0]     cell_word_o;

  text_console_cursor_engine_unit #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .target_column_i  (target_column_i),
    .target_row_i     (target_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .cursor_position_o(cursor_position_o),
    .cell_word_o      (cell_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the console state
  logic [CELL_W-1:0]  screen_shadow [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] fg_shadow  = FG_RESET;
  logic [COLOR_W-1:0] bg_shadow  = BG_RESET;
  logic [ROW_W-1:0]   top_shadow = TOP_RESET;

  console_cmd_t   console_cmds [$];
  cursor_report_t reports_due [$];
  console_cmd_t   offered;
  int             gap_left;
  int             settle_count;
  bit             send_burst;
  int             stall_left;
  bit             take_burst;
  int             mismatch_count;
  int             quiet_cycles;

  // first row of the scrolling area, clamped to the screen
  function automatic int area_top();
    return (top_shadow >= ROWS) ? ROWS - 1 : int'(top_shadow);
  endfunction

  function automatic logic [CELL_W-1:0] glyph_cell(logic [CHAR_W-1:0] ch);
    return {bg_shadow, fg_shadow, ch};
  endfunction

  // line feed, scrolling the area when it runs off the bottom
  function automatic void advance_line();
    int top;
    top = area_top();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = top * COLUMNS; i < (ROWS - 1) * COLUMNS; i++)
        screen_shadow[i] = screen_shadow[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
        screen_shadow[i] = glyph_cell(CH_SPACE);
      cur_row = ROWS - 1;
    end
  endfunction

  // apply one console item to the shadow and return the cursor report
  function automatic cursor_report_t console_step(console_cmd_t c);
    int             top;
    int             tc;
    int             tr;
    int             pos;
    logic [CELL_W-1:0] word;
    cursor_report_t r;
    top  = area_top();
    tc   = (c.col >= COLUMNS) ? COLUMNS - 1 : int'(c.col);
    tr   = (c.row >= ROWS) ? ROWS - 1 : int'(c.row);
    word = '0;
    case (c.action)
      ACT_PUT: begin
        if (cur_row < top) cur_row = top;
        if (c.ch == CH_LF) begin
          advance_line();
        end else if (c.ch == CH_CR) begin
          cur_col = 0;
        end else if (c.ch == CH_TAB) begin
          cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
          if (cur_col >= COLUMNS) advance_line();
        end else begin
          screen_shadow[cur_row * COLUMNS + cur_col] = glyph_cell(c.ch);
          cur_col++;
          if (cur_col >= COLUMNS) advance_line();
        end
      end
      ACT_BACK: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > top) begin
          cur_row--;
          cur_col = COLUMNS - 1;
        end
        screen_shadow[cur_row * COLUMNS + cur_col] = glyph_cell(CH_SPACE);
      end
      ACT_CLEAR: begin
        for (int i = top * COLUMNS; i < CELLS; i++)
          screen_shadow[i] = glyph_cell(CH_SPACE);
        cur_col = 0;
        cur_row = top;
      end
      ACT_MOVE: begin
        cur_col = tc;
        cur_row = tr;
      end
      ACT_READ: word = screen_shadow[tr * COLUMNS + tc];
      default: ;
    endcase
    pos        = cur_row * COLUMNS + cur_col;
    r.col      = COL_W'(cur_col);
    r.row      = ROW_W'(cur_row);
    r.pos      = POS_W'(pos);
    r.cell_val = word;
    return r;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FG:  fg_shadow  = val[COLOR_W-1:0];
      CFG_BG:  bg_shadow  = val[COLOR_W-1:0];
      CFG_TOP: top_shadow = val;
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                                   logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    console_cmd_t c;
    c        = '0;
    c.action = act;
    c.ch     = ch;
    c.col    = col;
    c.row    = row;
    console_cmds.push_back(c);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx,
                                  logic [CFG_DATA_W-1:0] val);
    console_cmd_t c;
    c         = '0;
    c.is_cfg  = 1'b1;
    c.reg_idx = idx;
    c.reg_val = val;
    console_cmds.push_back(c);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < REPORT_CAP)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // input driver: register writes only once every report is back
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    console_cmd_t c;
    logic         valid_n;
    logic         we_n;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cfg_we_i     <= 1'b0;
      gap_left     = 0;
      settle_count = 0;
    end else begin
      valid_n = in_valid_i;
      we_n    = 1'b0;
      if (in_valid_i && in_ready_o) begin
        reports_due.push_back(console_step(offered));
        valid_n  = 1'b0;
        gap_left = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      end
      if (!valid_n && console_cmds.size() > 0) begin
        if (console_cmds[0].is_cfg) begin
          if (reports_due.size() != 0) begin
            settle_count = 0;
          end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
          end else begin
            c = console_cmds.pop_front();
            we_n         = 1'b1;
            cfg_index_i  <= c.reg_idx;
            cfg_data_i   <= c.reg_val;
            apply_setting(c.reg_idx, c.reg_val);
            settle_count = 0;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          c = console_cmds.pop_front();
          offered         = c;
          action_i        <= c.action;
          char_code_i     <= c.ch;
          target_column_i <= c.col;
          target_row_i    <= c.row;
          valid_n         = 1'b1;
        end
      end
      in_valid_i <= valid_n;
      cfg_we_i   <= we_n;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : report_monitor
    cursor_report_t seen;
    cursor_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen = {cursor_column_o, cursor_row_o, cursor_position_o, cell_word_o};
        if (reports_due.size() == 0) begin
          if (mismatch_count < REPORT_CAP)
            $display("%0t: unexpected result transfer: expected none, actual %h",
                     $time, seen);
          mismatch_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("cursor_column", int'(want.col), int'(seen.col));
          check_field("cursor_row", int'(want.row), int'(seen.row));
          check_field("cursor_position", int'(want.pos), int'(seen.pos));
          check_field("cell_word", int'(want.cell_val), int'(seen.cell_val));
        end
        stall_left = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[text_console_cursor_engine_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int                 pick;
    logic [ACT_W-1:0]   act;
    logic [CHAR_W-1:0]  ch;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    rst_ni = 1'b0;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = RESET_CELL;
    cur_col        = 0;
    cur_row        = area_top();
    mismatch_count = 0;
    send_burst     = 1'b0;
    take_burst     = 1'b0;

    // directed: edges, control characters, wraps, scrolls, saturation
    add_item(ACT_READ, 8'h00, 7'd0, 5'd0);
    add_item(ACT_PUT, 8'h48, 7'd0, 5'd0);
    add_item(ACT_PUT, 8'hFF, 7'd0, 5'd0);
    add_item(ACT_PUT, 8'h00, 7'd0, 5'd0);
    add_item(ACT_PUT, CH_TAB, 7'd0, 5'd0);
    add_item(ACT_PUT, CH_CR, 7'd0, 5'd0);
    // backspace at column 0 of the top terminal row stays put
    add_item(ACT_BACK, 8'h00, 7'd0, 5'd0);
    add_item(ACT_READ, 8'h00, 7'd0, 5'd1);
    add_item(ACT_MOVE, 8'h00, 7'd127, 5'd31);
    add_item(ACT_PUT, 8'h5A, 7'd0, 5'd0);
    add_item(ACT_MOVE, 8'h00, 7'd77, 5'd24);
    add_item(ACT_PUT, CH_TAB, 7'd0, 5'd0);
    add_item(ACT_PUT, CH_LF, 7'd0, 5'd0);
    // cursor above the terminal area
    add_item(ACT_MOVE, 8'h00, 7'd0, 5'd0);
    add_item(ACT_BACK, 8'h00, 7'd0, 5'd0);
    add_item(ACT_PUT, 8'h61, 7'd0, 5'd0);
    // backspace across a row boundary
    add_item(ACT_MOVE, 8'h00, 7'd0, 5'd5);
    add_item(ACT_BACK, 8'h00, 7'd0, 5'd0);
    add_item(ACT_READ, 8'h00, 7'd127, 5'd31);
    add_item(ACT_READ, 8'h00, 7'd79, 5'd24);
    add_item(ACT_UNUSED_FIRST, 8'hFF, 7'd127, 5'd31);
    add_item(ACT_UNUSED_FIRST + 3'd1, 8'h00, 7'd0, 5'd0);
    add_item(ACT_UNUSED_LAST, 8'h41, 7'd64, 5'd16);
    add_item(ACT_CLEAR, 8'h00, 7'd0, 5'd0);
    add_item(ACT_READ, 8'h00, 7'd0, 5'd0);

    // random phases, each with its own colors and terminal area
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: begin
          add_cfg(CFG_FG, 5'd0);
          add_cfg(CFG_BG, 5'd15);
          add_cfg(CFG_TOP, 5'd0);
        end
        2: begin
          add_cfg(CFG_FG, 5'd15);
          add_cfg(CFG_BG, 5'd0);
          add_cfg(CFG_TOP, 5'd24);
        end
        3: begin
          // top row past the screen acts as the last row
          add_cfg(CFG_FG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_BG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_TOP, 5'd31);
          add_cfg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 31)));
        end
        4: begin
          add_cfg(CFG_FG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_BG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_TOP, 5'd12);
        end
        default: begin
          add_cfg(CFG_FG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_BG, CFG_DATA_W'($urandom_range(0, 15)));
          add_cfg(CFG_TOP, CFG_DATA_W'($urandom_range(0, 31)));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        col  = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, 79)) :
                                              COL_W'($urandom_range(80, 127));
        row  = ($urandom_range(0, 99) < 85) ? ROW_W'($urandom_range(0, 24)) :
                                              ROW_W'($urandom_range(25, 31));
        if (pick < 50) begin
          act  = ACT_PUT;
          pick = $urandom_range(0, 99);
          if (pick < 7) ch = CH_LF;
          else if (pick < 11) ch = CH_CR;
          else if (pick < 17) ch = CH_TAB;
        end else if (pick < 62) begin
          act = ACT_BACK;
        end else if (pick < 64) begin
          act = ACT_CLEAR;
        end else if (pick < 78) begin
          // lean toward the bottom rows so line feeds scroll
          act = ACT_MOVE;
          if ($urandom_range(0, 99) < 40) row = ROW_W'($urandom_range(20, 24));
        end else if (pick < 97) begin
          act = ACT_READ;
        end else begin
          act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        end
        add_item(act, ch, col, row);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (console_cmds.size() != 0 || in_valid_i || reports_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[text_console_cursor_engine_unit] OK");
    end else begin
      $display("[text_console_cursor_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tccu_pkg.sv
sv/tccu_screen_ram.sv
sv/tccu_tab_unit.sv
sv/text_console_cursor_engine_unit.sv
test/text_console_cursor_engine_unit_tb.sv
